### rtl/core/sawct_pkg.sv
`default_nettype none

package sawct_pkg;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // fixed field widths of the ports
    localparam int ADDR_W    = 32;
    localparam int BLK_OUT_W = 28;
    localparam int TOTAL_W   = 32;
    localparam int DIRTY_W   = 9;
    localparam int STAMP_W   = 32;

    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [BLK_OUT_W-1:0] block_out_t;
    typedef logic [TOTAL_W-1:0]   total_t;
    typedef logic [DIRTY_W-1:0]   dirty_out_t;
    typedef logic [STAMP_W-1:0]   stamp_t;

    localparam total_t TOTAL_MAX = '1;

endpackage

`default_nettype wire

### rtl/core/sawct_ram.sv
`default_nettype none

module sawct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/set_assoc_writeback_cache_tags_top.sv
// an access passes the split, lookup and output registers; read hits rewrite no row
// throughput: one access per cycle unless stalled; each reads its set's row once
// a row just rewritten is forwarded to an access of the same set that follows directly
// reset: valid bits, totals and the output valid clear at once, no clearing pass
`default_nettype none

module set_assoc_writeback_cache_tags_top #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  op,
    input  wire sawct_pkg::addr_t      address,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       tag_hit,
    output logic                       counted_miss,
    output logic                       writeback_valid,
    output sawct_pkg::block_out_t      writeback_block,
    output logic                       fill_valid,
    output sawct_pkg::block_out_t      fill_block,
    output sawct_pkg::total_t          hit_total,
    output sawct_pkg::total_t          miss_total,
    output sawct_pkg::dirty_out_t      dirty_total
);

    localparam int OFF_W     = $clog2(BLOCK_BYTES + 1) - 1;
    localparam int BLK_W     = sawct_pkg::ADDR_W - OFF_W;
    localparam int CEIL_L    = $clog2(SETS);
    localparam int FLOOR_L   = $clog2(SETS + 1) - 1;
    localparam int SET_W     = (SETS > 1) ? CEIL_L : 1;
    localparam int TAG_W     = BLK_W - FLOOR_L;
    localparam int SHIFT     = BLK_W + CEIL_L;
    localparam int PROD_W    = 2 * BLK_W + 1;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS);
    localparam logic [BLK_W:0] RECIP = RECIP_FULL[BLK_W:0];
    localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int STAMP_W   = sawct_pkg::STAMP_W;
    localparam int WAY_W     = TAG_W + 1 + STAMP_W;
    localparam int ROW_W     = WAYS * WAY_W + STAMP_W;
    localparam int DCNT_W    = $clog2(SETS * WAYS + 1);

    // ---------------------------------------------------------------
    // handshake chain: input -> split stage -> lookup stage -> output
    // ---------------------------------------------------------------
    logic a_valid_reg;
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_go;
    logic s1_free;
    logic a_go;
    logic a_free;
    logic in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && out_free;
    assign s1_free  = !s1_valid_reg || s1_go;
    assign a_go     = a_valid_reg && s1_free;
    assign a_free   = !a_valid_reg || a_go;
    assign in_stall = !a_free;
    assign in_take  = in_valid && a_free;
    assign out_valid = out_valid_reg;

    // ---------------------------------------------------------------
    // split stage: block / SETS by reciprocal multiply on the way in
    // ---------------------------------------------------------------
    logic [BLK_W-1:0]  block_in;
    logic [PROD_W-1:0] div_prod;
    logic [TAG_W-1:0]  tag_in;

    assign block_in = address[sawct_pkg::ADDR_W-1:OFF_W];
    assign div_prod = {{(BLK_W + 1){1'b0}}, block_in} * {{BLK_W{1'b0}}, RECIP};
    assign tag_in   = div_prod[SHIFT +: TAG_W];

    logic             a_op_reg;
    logic [BLK_W-1:0] a_block_reg;
    logic [TAG_W-1:0] a_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_free)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_op_reg    <= op;
            a_block_reg <= block_in;
            a_tag_reg   <= tag_in;
        end
    end

    // remainder gives the set
    logic [BLK_W-1:0] tag_times_sets;
    logic [BLK_W-1:0] set_rem;
    logic [SET_W-1:0] a_set;

    assign tag_times_sets = BLK_W'(a_tag_reg) * BLK_W'(SETS);
    assign set_rem        = a_block_reg - tag_times_sets;
    assign a_set          = set_rem[SET_W-1:0];

    // ---------------------------------------------------------------
    // row memory: per way tag, dirty, stamp; plus the set counter
    // ---------------------------------------------------------------
    logic             s1_op_reg;
    logic [BLK_W-1:0] s1_block_reg;
    logic [TAG_W-1:0] s1_tag_reg;
    logic [SET_W-1:0] s1_set_reg;
    logic             s1_bypass_reg;
    logic [ROW_W-1:0] fwd_row_reg;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] row_cur;
    logic [ROW_W-1:0] row_new;
    logic             touched;

    sawct_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (s1_go && touched),
        .waddr (s1_set_reg),
        .wdata (row_new),
        .re    (a_go),
        .raddr (a_set),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_bypass_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg  <= a_valid_reg;
            s1_bypass_reg <= a_go && s1_go && (a_set == s1_set_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_go)
        begin
            s1_op_reg    <= a_op_reg;
            s1_block_reg <= a_block_reg;
            s1_tag_reg   <= a_tag_reg;
            s1_set_reg   <= a_set;
        end
        if (s1_go)
        begin
            fwd_row_reg <= row_new;
        end
    end

    // ---------------------------------------------------------------
    // lookup stage: hit search, victim choice, row update
    // ---------------------------------------------------------------
    logic [WAYS-1:0]       valid_reg [SETS];
    logic [WAYS-1:0]       set_valid;
    logic [TAG_W-1:0]      way_tag   [WAYS];
    logic                  way_dirty [WAYS];
    sawct_pkg::stamp_t     way_stamp [WAYS];
    logic [WAYS-1:0]       is_old;
    sawct_pkg::stamp_t     counter;
    logic                  hit;
    logic [WAY_IDX_W-1:0]  hit_way;
    logic [WAY_IDX_W-1:0]  inv_way;
    logic [WAY_IDX_W-1:0]  old_way;
    logic [WAY_IDX_W-1:0]  victim;
    logic [WAY_IDX_W-1:0]  sel_way;
    logic                  is_write;
    logic                  wb;
    logic                  miss_cnt;
    logic                  hit_cnt;
    logic                  dirty_up;
    logic                  dirty_down;

    assign row_cur   = s1_bypass_reg ? fwd_row_reg : ram_rdata;
    assign set_valid = valid_reg[s1_set_reg];
    assign is_write  = (s1_op_reg == sawct_pkg::OP_WRITE);

    // unpack the row
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            way_stamp[w] = row_cur[w * WAY_W +: STAMP_W];
            way_dirty[w] = row_cur[w * WAY_W + STAMP_W];
            way_tag[w]   = row_cur[w * WAY_W + STAMP_W + 1 +: TAG_W];
        end
        counter = (|set_valid) ? row_cur[WAYS * WAY_W +: STAMP_W] : '0;
    end

    // lowest valid way holding the tag
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (set_valid[w] && (way_tag[w] == s1_tag_reg))
            begin
                hit     = 1'b1;
                hit_way = WAY_IDX_W'(w);
            end
        end
    end

    // victim: lowest invalid way, else the oldest stamp with ties to the lower way
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            is_old[w] = 1'b1;
            for (int v = 0; v < WAYS; v++)
            begin
                if ((v < w) && !(way_stamp[w] < way_stamp[v]))
                begin
                    is_old[w] = 1'b0;
                end
                if ((v > w) && !(way_stamp[w] <= way_stamp[v]))
                begin
                    is_old[w] = 1'b0;
                end
            end
        end
        inv_way = '0;
        old_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!set_valid[w])
            begin
                inv_way = WAY_IDX_W'(w);
            end
            if (is_old[w])
            begin
                old_way = WAY_IDX_W'(w);
            end
        end
        victim = (&set_valid) ? old_way : inv_way;
    end

    // outcome of the access
    assign wb         = !hit && set_valid[victim] && way_dirty[victim];
    assign touched    = is_write || !hit;
    assign sel_way    = hit ? hit_way : victim;
    assign miss_cnt   = !hit && (!is_write || wb);
    assign hit_cnt    = !miss_cnt;
    assign dirty_up   = is_write && (hit ? !way_dirty[hit_way] : !wb);
    assign dirty_down = !is_write && wb;

    // rewritten row
    always_comb
    begin
        row_new = row_cur;
        for (int w = 0; w < WAYS; w++)
        begin
            if (touched && (WAY_IDX_W'(w) == sel_way))
            begin
                row_new[w * WAY_W +: STAMP_W] = counter;
                row_new[w * WAY_W + STAMP_W]  = is_write;
                if (!hit)
                begin
                    row_new[w * WAY_W + STAMP_W + 1 +: TAG_W] = s1_tag_reg;
                end
            end
        end
        if (touched)
        begin
            row_new[WAYS * WAY_W +: STAMP_W] = counter + 1'b1;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else if (s1_go && !hit)
        begin
            valid_reg[s1_set_reg][victim] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // running totals
    // ---------------------------------------------------------------
    sawct_pkg::total_t hits_reg;
    sawct_pkg::total_t hits_next;
    sawct_pkg::total_t misses_reg;
    sawct_pkg::total_t misses_next;
    logic [DCNT_W-1:0] dirty_reg;
    logic [DCNT_W-1:0] dirty_next;

    always_comb
    begin
        hits_next   = hits_reg;
        misses_next = misses_reg;
        dirty_next  = dirty_reg;
        if (hit_cnt && (hits_reg != sawct_pkg::TOTAL_MAX))
        begin
            hits_next = hits_reg + 1'b1;
        end
        if (miss_cnt && (misses_reg != sawct_pkg::TOTAL_MAX))
        begin
            misses_next = misses_reg + 1'b1;
        end
        if (dirty_up)
        begin
            dirty_next = dirty_reg + 1'b1;
        end
        else if (dirty_down)
        begin
            dirty_next = dirty_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg   <= '0;
            misses_reg <= '0;
            dirty_reg  <= '0;
        end
        else if (s1_go)
        begin
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            dirty_reg  <= dirty_next;
        end
    end

    // ---------------------------------------------------------------
    // result word register
    // ---------------------------------------------------------------
    logic [31:0] wb_full;

    assign wb_full = 32'(way_tag[victim]) * 32'(SETS) + 32'(s1_set_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            tag_hit         <= hit;
            counted_miss    <= miss_cnt;
            writeback_valid <= wb;
            writeback_block <= wb ? wb_full[sawct_pkg::BLK_OUT_W-1:0] : '0;
            fill_valid      <= !hit && !is_write;
            fill_block      <= (!hit && !is_write) ?
                               sawct_pkg::block_out_t'(s1_block_reg) : '0;
            hit_total       <= hits_next;
            miss_total      <= misses_next;
            dirty_total     <= sawct_pkg::dirty_out_t'(dirty_next);
        end
    end

endmodule

`default_nettype wire

### bench/set_assoc_writeback_cache_tags_top_tb.sv
`timescale 1ns / 1ps

module set_assoc_writeback_cache_tags_top_tb;

    localparam int SETS     = 64;
    localparam int WAYS     = 4;
    localparam int OFFSET_W = 4;
    localparam int SET_W    = 6;
    localparam int TAG_W    = 22;
    localparam int LINES    = SETS * WAYS;

    typedef logic [TAG_W-1:0] tag_t;

    // one result word as the block reports it
    typedef struct packed {
        logic                  tag_hit;
        logic                  counted_miss;
        logic                  writeback_valid;
        sawct_pkg::block_out_t writeback_block;
        logic                  fill_valid;
        sawct_pkg::block_out_t fill_block;
        sawct_pkg::total_t     hit_total;
        sawct_pkg::total_t     miss_total;
        sawct_pkg::dirty_out_t dirty_total;
    } outcome_t;

    // tag, valid, dirty and age state of the cache, plus the words still owed
    class cache_tag_scoreboard;
        tag_t              line_tag [LINES];
        bit                line_valid [LINES];
        bit                line_dirty [LINES];
        sawct_pkg::stamp_t line_stamp [LINES];
        sawct_pkg::stamp_t set_counter [SETS];
        sawct_pkg::total_t hits_kept;
        sawct_pkg::total_t misses_kept;
        int                dirty_kept;
        outcome_t          expected_outcomes [$];
        int                mismatches;
        int                failures;

        function new();
            for (int i = 0; i < LINES; i++)
            begin
                line_tag[i]   = '0;
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_stamp[i] = '0;
            end
            for (int s = 0; s < SETS; s++)
            begin
                set_counter[s] = '0;
            end
            hits_kept   = '0;
            misses_kept = '0;
            dirty_kept  = 0;
            mismatches  = 0;
            failures    = 0;
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        // lowest invalid way, else the oldest stamp with the lowest way on a tie
        function int victim_way(int base);
            int best;
            best = 0;
            for (int w = 0; w < WAYS; w++)
            begin
                if (!line_valid[base + w])
                    return w;
            end
            for (int w = 1; w < WAYS; w++)
            begin
                if (line_stamp[base + w] < line_stamp[base + best])
                    best = w;
            end
            return best;
        endfunction

        // predict the word for one accepted access and update the cache state
        function void note_access(logic access_op, sawct_pkg::addr_t addr);
            outcome_t                        r;
            logic [sawct_pkg::BLK_OUT_W-1:0] blk;
            logic [SET_W-1:0]                set_idx;
            tag_t                            tag;
            int                              base;
            int                              hit_way;
            int                              idx;
            bit                              is_write;

            is_write = (access_op == sawct_pkg::OP_WRITE);
            blk      = addr[sawct_pkg::ADDR_W-1:OFFSET_W];
            set_idx  = blk[SET_W-1:0];
            tag      = blk[sawct_pkg::BLK_OUT_W-1:SET_W];
            base     = int'(set_idx) * WAYS;
            hit_way  = -1;
            r        = '0;

            for (int w = 0; w < WAYS; w++)
            begin
                if (hit_way < 0 && line_valid[base + w] && line_tag[base + w] == tag)
                    hit_way = w;
            end

            if (hit_way >= 0)
            begin
                idx = base + hit_way;
                r.tag_hit = 1'b1;
                if (is_write)
                begin
                    if (!line_dirty[idx])
                        dirty_kept++;
                    line_dirty[idx] = 1'b1;
                    line_stamp[idx] = set_counter[set_idx];
                    set_counter[set_idx]++;
                end
                if (hits_kept != sawct_pkg::TOTAL_MAX)
                    hits_kept++;
            end
            else
            begin
                idx = base + victim_way(base);
                if (line_valid[idx] && line_dirty[idx])
                begin
                    r.writeback_valid = 1'b1;
                    r.writeback_block = {line_tag[idx], set_idx};
                end
                if (is_write)
                begin
                    if (r.writeback_valid)
                    begin
                        r.counted_miss = 1'b1;
                        if (misses_kept != sawct_pkg::TOTAL_MAX)
                            misses_kept++;
                    end
                    else
                    begin
                        if (hits_kept != sawct_pkg::TOTAL_MAX)
                            hits_kept++;
                        dirty_kept++;
                    end
                    line_dirty[idx] = 1'b1;
                end
                else
                begin
                    r.counted_miss = 1'b1;
                    r.fill_valid   = 1'b1;
                    r.fill_block   = blk;
                    if (misses_kept != sawct_pkg::TOTAL_MAX)
                        misses_kept++;
                    if (r.writeback_valid)
                        dirty_kept--;
                    line_dirty[idx] = 1'b0;
                end
                line_tag[idx]   = tag;
                line_valid[idx] = 1'b1;
                line_stamp[idx] = set_counter[set_idx];
                set_counter[set_idx]++;
            end

            r.hit_total   = hits_kept;
            r.miss_total  = misses_kept;
            r.dirty_total = sawct_pkg::dirty_out_t'(dirty_kept);
            expected_outcomes.push_back(r);
        endfunction

        function bit field_ok(string field, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v === exp_v)
                return 1'b1;
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %h got %h", $realtime, field, exp_v, act_v);
            return 1'b0;
        endfunction

        // compare one delivered word with the oldest prediction
        function void check_result(outcome_t got);
            outcome_t e;
            bit       ok;
            if (expected_outcomes.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with none expected", $realtime);
                return;
            end
            e  = expected_outcomes.pop_front();
            ok = 1'b1;
            ok &= field_ok("tag_hit", 32'(e.tag_hit), 32'(got.tag_hit));
            ok &= field_ok("counted_miss", 32'(e.counted_miss), 32'(got.counted_miss));
            ok &= field_ok("writeback_valid", 32'(e.writeback_valid),
                           32'(got.writeback_valid));
            ok &= field_ok("writeback_block", 32'(e.writeback_block),
                           32'(got.writeback_block));
            ok &= field_ok("fill_valid", 32'(e.fill_valid), 32'(got.fill_valid));
            ok &= field_ok("fill_block", 32'(e.fill_block), 32'(got.fill_block));
            ok &= field_ok("hit_total", e.hit_total, got.hit_total);
            ok &= field_ok("miss_total", e.miss_total, got.miss_total);
            ok &= field_ok("dirty_total", 32'(e.dirty_total), 32'(got.dirty_total));
            if (!ok)
                failures++;
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  op;
    sawct_pkg::addr_t      address;
    logic                  out_valid;
    logic                  out_stall;
    logic                  tag_hit;
    logic                  counted_miss;
    logic                  writeback_valid;
    sawct_pkg::block_out_t writeback_block;
    logic                  fill_valid;
    sawct_pkg::block_out_t fill_block;
    sawct_pkg::total_t     hit_total;
    sawct_pkg::total_t     miss_total;
    sawct_pkg::dirty_out_t dirty_total;

    cache_tag_scoreboard sb;

    int           send_idle_pct;
    int           stall_pct;
    int           hold_off_left;
    tag_t         tag_pool [8];
    logic [SET_W-1:0] hot_sets [4];

    set_assoc_writeback_cache_tags_top #(
        .SETS        (SETS),
        .WAYS        (WAYS),
        .BLOCK_BYTES (16)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .address         (address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .tag_hit         (tag_hit),
        .counted_miss    (counted_miss),
        .writeback_valid (writeback_valid),
        .writeback_block (writeback_block),
        .fill_valid      (fill_valid),
        .fill_block      (fill_block),
        .hit_total       (hit_total),
        .miss_total      (miss_total),
        .dirty_total     (dirty_total)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                out_stall <= 1'b1;
                hold_off_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{tag_hit, counted_miss, writeback_valid, writeback_block,
                              fill_valid, fill_block, hit_total, miss_total, dirty_total});
    end

    // offer one access word, return at the falling edge after it is taken
    task automatic send_word(input logic access_op, input sawct_pkg::addr_t addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= access_op;
        address  <= addr;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_access(access_op, addr);
        @(negedge clk);
    endtask

    // park the sender until every predicted word has come back or a guard runs out
    task automatic wait_results();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.pending() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
    endtask

    task automatic refresh_pools();
        for (int k = 0; k < 8; k++)
        begin
            tag_pool[k] = TAG_W'($urandom());
        end
        for (int k = 0; k < 4; k++)
        begin
            hot_sets[k] = SET_W'($urandom_range(SETS - 1));
        end
    endtask

    // mostly pooled tags, half on hot sets, so that hits, evictions and write-backs mix
    function automatic sawct_pkg::addr_t pick_address();
        logic [SET_W-1:0] s;
        tag_t             t;
        if ($urandom_range(9) == 0)
            return sawct_pkg::addr_t'($urandom());
        if ($urandom_range(1) == 0)
            s = hot_sets[$urandom_range(3)];
        else
            s = SET_W'($urandom_range(SETS - 1));
        t = tag_pool[$urandom_range(7)];
        return {t, s, OFFSET_W'($urandom_range(15))};
    endfunction

    function automatic logic pick_op();
        return ($urandom_range(1) == 0) ? sawct_pkg::OP_READ : sawct_pkg::OP_WRITE;
    endfunction

    initial
    begin
        int   send_pcts [4];
        int   stall_pcts [4];
        tag_t sweep_base;

        send_pcts  = '{0, 47, 0, 25};
        stall_pcts = '{0, 0, 47, 25};

        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = sawct_pkg::OP_READ;
        address       = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_left = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: miss, hit, write allocate, address extremes, set 0 eviction order
        send_word(sawct_pkg::OP_READ,  32'h0000_0000);
        send_word(sawct_pkg::OP_READ,  32'h0000_000F);
        send_word(sawct_pkg::OP_WRITE, 32'h0000_0004);
        send_word(sawct_pkg::OP_WRITE, 32'hFFFF_FFFF);
        send_word(sawct_pkg::OP_READ,  32'hFFFF_FFF0);
        send_word(sawct_pkg::OP_WRITE, 32'h0000_0400);
        send_word(sawct_pkg::OP_WRITE, 32'h0000_0800);
        send_word(sawct_pkg::OP_READ,  32'h0000_0C00);
        // set full: dirty victim on write miss counts as a miss
        send_word(sawct_pkg::OP_WRITE, 32'h0000_1000);
        // dirty victim on read miss
        send_word(sawct_pkg::OP_READ,  32'h0000_1400);
        // read hit must not refresh the age of its way
        send_word(sawct_pkg::OP_READ,  32'h0000_0800);
        send_word(sawct_pkg::OP_READ,  32'h0000_1800);
        // write hit on a clean line
        send_word(sawct_pkg::OP_WRITE, 32'h0000_0C00);
        // write miss on a dirty victim again counts as a miss
        send_word(sawct_pkg::OP_WRITE, 32'hFFFF_FC00);
        send_word(sawct_pkg::OP_READ,  32'h0000_0000);
        send_word(sawct_pkg::OP_READ,  32'hFFFF_FC0F);
        send_word(sawct_pkg::OP_WRITE, 32'hFFFF_FFF8);
        send_word(sawct_pkg::OP_READ,  32'hAAAA_AAAA);
        send_word(sawct_pkg::OP_WRITE, 32'h5555_5555);
        send_word(sawct_pkg::OP_READ,  32'h8000_0000);
        send_word(sawct_pkg::OP_WRITE, 32'h7FFF_FFFF);
        wait_results();

        // write four fresh tags into every set: every line ends dirty
        sweep_base = TAG_W'($urandom());
        for (int s = 0; s < SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                send_word(sawct_pkg::OP_WRITE, {sweep_base[TAG_W-1:2], 2'(w), SET_W'(s),
                                                OFFSET_W'($urandom_range(15))});
            end
        end
        wait_results();

        // random phases with different idling on each side
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pcts[p];
            stall_pct     = stall_pcts[p];
            refresh_pools();
            for (int i = 0; i < 430; i++)
            begin
                send_word(pick_op(), pick_address());
            end
            wait_results();
        end

        // long receiver hold-off while the sender keeps pushing
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_left = 300;
        for (int i = 0; i < 40; i++)
        begin
            send_word(pick_op(), pick_address());
        end
        wait_results();

        repeat (12) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/sawct_pkg.sv
rtl/core/sawct_ram.sv
rtl/core/set_assoc_writeback_cache_tags_top.sv
bench/set_assoc_writeback_cache_tags_top_tb.sv
